>>> hw/rtl/sgdm_pkg.sv
// Shared types, constants and helpers for the SGD momentum weight update block.
`timescale 1ns / 1ps

package sgdm_pkg;

    // Velocity store geometry; the depth is a power of two, so the element
    // index wraps by dropping its upper bits.
    localparam int VEL_DEPTH = 4096;
    localparam int VEL_AW    = $clog2(VEL_DEPTH);
    localparam int IDX_W     = 12;

    // Gradient sum magnitude width and one divider step per quotient bit.
    localparam int MAG_W     = 33;
    localparam int DIV_STEPS = MAG_W;
    localparam int BATCH_W   = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_L1_DECAY        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_L2_DECAY        = 3'd4;

    localparam logic signed [35:0] Q_MAX36 = 36'sd2147483647;
    localparam logic signed [35:0] Q_MIN36 = -36'sd2147483648;

    typedef struct packed {
        logic [IDX_W-1:0]   elem_index;
        logic signed [31:0] weight_in;
        logic signed [31:0] grad_in;
        logic               trainable;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] weight_out;
        logic               saturated;
    } out_item_t;

    // Per-item data that rides alongside the divider.
    typedef struct packed {
        logic [IDX_W-1:0]   elem_index;
        logic signed [31:0] weight;
        logic               trainable;
        logic               neg;
    } side_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } clip_t;

    function automatic clip_t clip36(input logic signed [35:0] v);
        clip_t r;
        if (v > Q_MAX36)
        begin
            r.val = Q_MAX36[31:0];
            r.sat = 1'b1;
        end
        else if (v < Q_MIN36)
        begin
            r.val = Q_MIN36[31:0];
            r.sat = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/sgd_momentum_weight_update.sv
// Top level of the SGD weight update with momentum and L1/L2 weight decay.
`timescale 1ns / 1ps

// Streams one weight update per clock cycle once the velocity store is ready.
// After reset the block clears all 4096 entries of the velocity store and
// holds in_stall high during that pass; configuration writes are taken as usual.
// An accepted transaction passes registers a and b, which form the decayed
// gradient sum, then the batch-size divider, which resolves one quotient
// bit per stage over 33 stages, then stages u1, u2 and the output register,
// which apply the learning rate, read and update the per-index velocity and
// saturate the result. Updates to the same element index on consecutive cycles
// are forwarded around the store, so throughput stays at one transaction per
// cycle. A stall on the output freezes the whole pipeline without loss.
module sgd_momentum_weight_update
    import sgdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    logic [BATCH_W-1:0] batch_size_reg;
    logic [15:0]        learning_rate_reg;
    logic [15:0]        momentum_factor_reg;
    logic [15:0]        l1_decay_reg;
    logic [15:0]        l2_decay_reg;

    logic               adv;
    logic               clearing;
    logic               accept;

    logic               a_valid_reg;
    in_item_t           a_item_reg;

    logic               b_valid_reg;
    in_item_t           b_item_reg;
    logic signed [48:0] b_l2prod_reg;

    logic signed [34:0] sum;
    logic signed [34:0] l1_term;
    logic signed [34:0] sum_abs;
    logic [BATCH_W-1:0] divisor;
    side_t              div_side;

    logic               d_valid;
    logic [MAG_W-1:0]   d_quot;
    side_t              d_side;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv || clearing;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_size_reg      <= BATCH_W'(1);
            learning_rate_reg   <= 16'd655;
            momentum_factor_reg <= 16'd0;
            l1_decay_reg        <= 16'd0;
            l2_decay_reg        <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BATCH_SIZE:      batch_size_reg      <= cfg_data;
                REG_LEARNING_RATE:   learning_rate_reg   <= cfg_data[15:0];
                REG_MOMENTUM_FACTOR: momentum_factor_reg <= cfg_data[15:0];
                REG_L1_DECAY:        l1_decay_reg        <= cfg_data[15:0];
                REG_L2_DECAY:        l2_decay_reg        <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg   <= in_data;
            b_item_reg   <= a_item_reg;
            b_l2prod_reg <= $signed({1'b0, l2_decay_reg}) * a_item_reg.weight_in;
        end
    end

    // Zero weight takes the negative L1 term.
    assign l1_term = (b_item_reg.weight_in > 32'sd0)
                   ? $signed({11'd0, l1_decay_reg, 8'd0})
                   : -$signed({11'd0, l1_decay_reg, 8'd0});
    assign sum = 35'(b_item_reg.grad_in) + 35'($signed(b_l2prod_reg[48:16])) + l1_term;
    assign sum_abs = sum[34] ? -sum : sum;
    assign divisor = (batch_size_reg == '0) ? BATCH_W'(1) : batch_size_reg;

    always_comb
    begin
        div_side.elem_index = b_item_reg.elem_index;
        div_side.weight     = b_item_reg.weight_in;
        div_side.trainable  = b_item_reg.trainable;
        div_side.neg        = sum[34];
    end

    sgdm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (b_valid_reg),
        .in_mag    (sum_abs[MAG_W-1:0]),
        .in_side   (div_side),
        .divisor   (divisor),
        .out_valid (d_valid),
        .out_quot  (d_quot),
        .out_side  (d_side)
    );

    sgdm_upd u_upd (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (d_valid),
        .in_quot         (d_quot),
        .in_side         (d_side),
        .learning_rate   (learning_rate_reg),
        .momentum_factor (momentum_factor_reg),
        .out_valid       (out_valid),
        .out_data        (out_data),
        .clearing        (clearing)
    );

endmodule

>>> hw/rtl/sgdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sgdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/sgdm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module sgdm_div
    import sgdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [MAG_W-1:0]   in_mag,
    input  side_t              in_side,
    input  logic [BATCH_W-1:0] divisor,
    output logic               out_valid,
    output logic [MAG_W-1:0]   out_quot,
    output side_t              out_side
);

    logic [BATCH_W-1:0] rem_reg   [DIV_STEPS];
    logic [MAG_W-1:0]   mag_reg   [DIV_STEPS];
    logic [MAG_W-1:0]   quot_reg  [DIV_STEPS];
    side_t              side_reg  [DIV_STEPS];
    logic               valid_reg [DIV_STEPS];

    logic [BATCH_W-1:0] rem_next  [DIV_STEPS];
    logic [MAG_W-1:0]   mag_next  [DIV_STEPS];
    logic [MAG_W-1:0]   quot_next [DIV_STEPS];

    logic [BATCH_W-1:0] cur_rem   [DIV_STEPS];
    logic [MAG_W-1:0]   cur_mag   [DIV_STEPS];
    logic [MAG_W-1:0]   cur_quot  [DIV_STEPS];
    logic [BATCH_W:0]   trial     [DIV_STEPS];

    always_comb
    begin
        cur_rem[0]  = '0;
        cur_mag[0]  = in_mag;
        cur_quot[0] = '0;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            cur_rem[k]  = rem_reg[k-1];
            cur_mag[k]  = mag_reg[k-1];
            cur_quot[k] = quot_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial[k]    = {cur_rem[k], cur_mag[k][MAG_W-1]};
            mag_next[k] = {cur_mag[k][MAG_W-2:0], 1'b0};
            if (trial[k] >= {1'b0, divisor})
            begin
                rem_next[k]  = BATCH_W'(trial[k] - {1'b0, divisor});
                quot_next[k] = {cur_quot[k][MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = trial[k][BATCH_W-1:0];
                quot_next[k] = {cur_quot[k][MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                mag_reg[k]  <= mag_next[k];
                quot_reg[k] <= quot_next[k];
            end
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_quot  = quot_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

>>> hw/rtl/sgdm_upd.sv
// Step scaling, velocity store with forwarding, saturation and output register.
`timescale 1ns / 1ps

module sgdm_upd
    import sgdm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [MAG_W-1:0] in_quot,
    input  side_t            in_side,
    input  logic [15:0]      learning_rate,
    input  logic [15:0]      momentum_factor,
    output logic             out_valid,
    output out_item_t        out_data,
    output logic             clearing
);

    logic                    mom;
    logic signed [33:0]      geff;
    logic signed [50:0]      step_prod;

    logic                    u1_valid_reg;
    logic signed [50:0]      u1_prod_reg;
    side_t                   u1_side_reg;

    logic                    u2_valid_reg;
    logic signed [31:0]      u2_v_reg;
    logic signed [34:0]      u2_step_reg;
    side_t                   u2_side_reg;

    logic                    lw_valid_reg;
    logic [VEL_AW-1:0]       lw_addr_reg;
    logic signed [31:0]      lw_data_reg;

    logic                    clr_active_reg;
    logic [VEL_AW-1:0]       clr_addr_reg;

    logic                    out_valid_reg;
    out_item_t               out_data_reg;
    out_item_t               out_data_next;

    logic [31:0]             rdata;
    logic                    hit_u2;
    logic                    hit_lw;
    logic signed [31:0]      v_fwd;
    logic [VEL_AW-1:0]       u1_addr;
    logic [VEL_AW-1:0]       u2_addr;

    logic signed [48:0]      decay_prod;
    logic signed [35:0]      dx;
    clip_t                   dx_c;
    clip_t                   w_mom;
    clip_t                   w_plain;
    logic                    item_we;

    logic                    ram_we;
    logic [VEL_AW-1:0]       ram_waddr;
    logic [31:0]             ram_wdata;

    assign mom = (momentum_factor != 16'd0);

    assign geff = in_side.neg ? -$signed({1'b0, in_quot}) : $signed({1'b0, in_quot});
    assign step_prod = $signed({1'b0, learning_rate}) * geff;

    assign u1_addr = u1_side_reg.elem_index[VEL_AW-1:0];
    assign u2_addr = u2_side_reg.elem_index[VEL_AW-1:0];

    // The item one stage ahead has not written yet, and the one two ahead wrote
    // in the same cycle as this read, so both are forwarded around the store.
    assign hit_u2 = u2_valid_reg && u2_side_reg.trainable && mom && (u2_addr == u1_addr);
    assign hit_lw = lw_valid_reg && (lw_addr_reg == u1_addr);

    always_comb
    begin
        if (hit_u2)
        begin
            v_fwd = dx_c.val;
        end
        else if (hit_lw)
        begin
            v_fwd = lw_data_reg;
        end
        else
        begin
            v_fwd = $signed(rdata);
        end
    end

    assign decay_prod = $signed({1'b0, momentum_factor}) * u2_v_reg;
    assign dx = 36'($signed(decay_prod[48:16])) - 36'(u2_step_reg);
    assign dx_c = clip36(dx);
    assign w_mom = clip36(36'(u2_side_reg.weight) + 36'(dx_c.val));
    assign w_plain = clip36(36'(u2_side_reg.weight) - 36'(u2_step_reg));

    always_comb
    begin
        if (!u2_side_reg.trainable)
        begin
            out_data_next.weight_out = u2_side_reg.weight;
            out_data_next.saturated  = 1'b0;
        end
        else if (mom)
        begin
            out_data_next.weight_out = w_mom.val;
            out_data_next.saturated  = w_mom.sat | dx_c.sat;
        end
        else
        begin
            out_data_next.weight_out = w_plain.val;
            out_data_next.saturated  = w_plain.sat;
        end
    end

    assign item_we   = adv && u2_valid_reg && u2_side_reg.trainable && mom;
    assign ram_we    = clr_active_reg || item_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : u2_addr;
    assign ram_wdata = clr_active_reg ? 32'd0 : dx_c.val;

    sgdm_ram #(
        .WIDTH (32),
        .DEPTH (VEL_DEPTH)
    ) u_vel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (in_side.elem_index[VEL_AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u1_valid_reg   <= 1'b0;
            u2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            lw_valid_reg   <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == VEL_AW'(VEL_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                u1_valid_reg  <= in_valid;
                u2_valid_reg  <= u1_valid_reg;
                out_valid_reg <= u2_valid_reg;
                lw_valid_reg  <= item_we;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_prod_reg  <= step_prod;
            u1_side_reg  <= in_side;
            u2_v_reg     <= v_fwd;
            u2_step_reg  <= u1_prod_reg[50:16];
            u2_side_reg  <= u1_side_reg;
            lw_addr_reg  <= u2_addr;
            lw_data_reg  <= dx_c.val;
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign clearing  = clr_active_reg;

    a_write_needs_momentum: assert property (@(posedge clk) disable iff (!rst_n)
        item_we |-> (mom && !clr_active_reg))
        else $error("velocity written by an item outside momentum mode");

    a_no_items_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!u1_valid_reg && !u2_valid_reg && !out_valid_reg))
        else $error("item in the update stages during the clearing pass");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !adv) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result lost while the output was stalled");

endmodule
